>>> hw/rtl/clnws_pkg.sv
package clnws_pkg;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [2:0] REQ_INIT   = 3'd0;
  localparam logic [2:0] REQ_CMD    = 3'd1;
  localparam logic [2:0] REQ_DATA   = 3'd2;
  localparam logic [2:0] REQ_CURSOR = 3'd3;
  localparam logic [2:0] REQ_CLEAR  = 3'd4;

  localparam logic [1:0] REG_ENABLE_PULSE = 2'd0;
  localparam logic [1:0] REG_CLEAR_WAIT   = 2'd1;
  localparam logic [1:0] REG_POWER_UP     = 2'd2;

  localparam logic [7:0] RST_ENABLE_PULSE = 8'd2;
  localparam logic [7:0] RST_CLEAR_WAIT   = 8'd5;
  localparam logic [7:0] RST_POWER_UP     = 8'd20;

  localparam logic [7:0] CLEAR_BYTE = 8'h01;
  localparam logic [7:0] ROW0_BASE  = 8'h80;
  localparam logic [7:0] ROW1_BASE  = 8'hC0;
  localparam logic [7:0] ROW2_BASE  = 8'h94;
  localparam logic [7:0] ROW3_BASE  = 8'hD4;
  localparam logic [7:0] HOME_ADDR  = 8'h80;

  localparam logic [2:0] INIT_LAST_IDX = 3'd4;
  localparam logic [1:0] PHASE_LAST    = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PWR,
    ST_BYTE
  } state_t;

  typedef struct packed {
    logic load;
    logic emit_pwr;
    logic emit_byte;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic byte_done;
    logic seq_more;
  } stat_t;

  function automatic logic [7:0] init_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h02;
      3'd1:    b = 8'h28;
      3'd2:    b = 8'h0C;
      3'd3:    b = 8'h06;
      default: b = CLEAR_BYTE;
    endcase
    return b;
  endfunction

endpackage

>>> hw/rtl/clnws_ctrl.sv
module clnws_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [2:0]          in_req_type,
  output logic                in_ready,
  input  clnws_pkg::stat_t    stat,
  output clnws_pkg::cmd_t     cmd
);

  clnws_pkg::state_t state_r;
  clnws_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= clnws_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      clnws_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (in_req_type) inside
            clnws_pkg::REQ_INIT: state_nxt = clnws_pkg::ST_PWR;
            clnws_pkg::REQ_CMD, clnws_pkg::REQ_DATA,
            clnws_pkg::REQ_CURSOR, clnws_pkg::REQ_CLEAR: state_nxt = clnws_pkg::ST_BYTE;
            default: state_nxt = clnws_pkg::ST_IDLE;
          endcase
        end
      end
      clnws_pkg::ST_PWR: begin
        if (stat.out_free) state_nxt = clnws_pkg::ST_BYTE;
      end
      clnws_pkg::ST_BYTE: begin
        if (stat.out_free && stat.byte_done && !stat.seq_more) begin
          state_nxt = clnws_pkg::ST_IDLE;
        end
      end
      default: state_nxt = clnws_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd.load      = 1'b0;
    cmd.emit_pwr  = 1'b0;
    cmd.emit_byte = 1'b0;
    unique case (state_r)
      clnws_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      clnws_pkg::ST_PWR:  cmd.emit_pwr  = stat.out_free;
      clnws_pkg::ST_BYTE: cmd.emit_byte = stat.out_free;
      default: ;
    endcase
  end

endmodule

>>> hw/rtl/clnws_dp.sv
module clnws_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  clnws_pkg::cmd_t               cmd,
  output clnws_pkg::stat_t              stat,
  input  logic [2:0]                    in_req_type,
  input  logic [7:0]                    in_value,
  input  logic [2:0]                    in_row,
  input  logic [4:0]                    in_column,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_reg_select,
  output logic                          out_enable,
  output logic [3:0]                    out_nibble,
  output logic [7:0]                    out_hold_ms,
  output logic                          out_last,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [clnws_pkg::PADDR_W-1:0] paddr,
  input  logic [clnws_pkg::PDATA_W-1:0] pwdata,
  output logic [clnws_pkg::PDATA_W-1:0] prdata
);

  logic [7:0] enable_pulse_r;
  logic [7:0] clear_wait_r;
  logic [7:0] power_up_r;

  logic       rs_r;
  logic       init_r;
  logic       clr_r;
  logic [7:0] byte_r;
  logic [2:0] idx_r;
  logic [1:0] phase_r;

  logic       out_valid_r;
  logic       out_rs_r;
  logic       out_en_r;
  logic [3:0] out_nib_r;
  logic [7:0] out_hold_r;
  logic       out_last_r;

  logic [1:0] reg_idx;
  logic [7:0] cursor_base;
  logic [7:0] cursor_addr;
  logic [7:0] load_byte;
  logic       seq_more;
  logic       fin_clear;
  logic       byte_done;
  logic [3:0] cur_nib;
  logic [7:0] cur_hold;

  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_pulse_r <= clnws_pkg::RST_ENABLE_PULSE;
      clear_wait_r   <= clnws_pkg::RST_CLEAR_WAIT;
      power_up_r     <= clnws_pkg::RST_POWER_UP;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        clnws_pkg::REG_ENABLE_PULSE: enable_pulse_r <= pwdata[7:0];
        clnws_pkg::REG_CLEAR_WAIT:   clear_wait_r   <= pwdata[7:0];
        clnws_pkg::REG_POWER_UP:     power_up_r     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      clnws_pkg::REG_ENABLE_PULSE: prdata = {24'd0, enable_pulse_r};
      clnws_pkg::REG_CLEAR_WAIT:   prdata = {24'd0, clear_wait_r};
      clnws_pkg::REG_POWER_UP:     prdata = {24'd0, power_up_r};
      default:                     prdata = '0;
    endcase
  end

  always_comb begin
    case (in_row)
      3'd0:    cursor_base = clnws_pkg::ROW0_BASE;
      3'd1:    cursor_base = clnws_pkg::ROW1_BASE;
      3'd2:    cursor_base = clnws_pkg::ROW2_BASE;
      3'd3:    cursor_base = clnws_pkg::ROW3_BASE;
      default: cursor_base = clnws_pkg::HOME_ADDR;
    endcase
    cursor_addr = in_row[2] ? clnws_pkg::HOME_ADDR : cursor_base + {3'd0, in_column};
  end

  always_comb begin
    case (in_req_type) inside
      clnws_pkg::REQ_INIT:                   load_byte = clnws_pkg::init_byte(3'd0);
      clnws_pkg::REQ_CMD, clnws_pkg::REQ_DATA: load_byte = in_value;
      clnws_pkg::REQ_CURSOR:                 load_byte = cursor_addr;
      default:                               load_byte = clnws_pkg::CLEAR_BYTE;
    endcase
  end

  assign seq_more  = init_r && (idx_r != clnws_pkg::INIT_LAST_IDX);
  assign fin_clear = clr_r || (init_r && (idx_r == clnws_pkg::INIT_LAST_IDX));
  assign byte_done = (phase_r == clnws_pkg::PHASE_LAST);
  assign cur_nib   = phase_r[1] ? byte_r[3:0] : byte_r[7:4];

  always_comb begin
    if (!phase_r[0]) begin
      cur_hold = enable_pulse_r;
    end else if (byte_done && fin_clear) begin
      cur_hold = clear_wait_r;
    end else begin
      cur_hold = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rs_r    <= (in_req_type == clnws_pkg::REQ_DATA);
      init_r  <= (in_req_type == clnws_pkg::REQ_INIT);
      clr_r   <= (in_req_type == clnws_pkg::REQ_CLEAR);
      byte_r  <= load_byte;
      idx_r   <= 3'd0;
      phase_r <= 2'd0;
    end else if (cmd.emit_byte) begin
      phase_r <= phase_r + 2'd1;
      if (byte_done && seq_more) begin
        idx_r  <= idx_r + 3'd1;
        byte_r <= clnws_pkg::init_byte(idx_r + 3'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_pwr || cmd.emit_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_pwr) begin
      out_rs_r   <= 1'b0;
      out_en_r   <= 1'b0;
      out_nib_r  <= 4'd0;
      out_hold_r <= power_up_r;
      out_last_r <= 1'b0;
    end else if (cmd.emit_byte) begin
      out_rs_r   <= rs_r;
      out_en_r   <= !phase_r[0];
      out_nib_r  <= cur_nib;
      out_hold_r <= cur_hold;
      out_last_r <= byte_done && !seq_more;
    end
  end

  assign stat.out_free  = !out_valid_r || out_ready;
  assign stat.byte_done = byte_done;
  assign stat.seq_more  = seq_more;

  assign out_valid      = out_valid_r;
  assign out_reg_select = out_rs_r;
  assign out_enable     = out_en_r;
  assign out_nibble     = out_nib_r;
  assign out_hold_ms    = out_hold_r;
  assign out_last       = out_last_r;

endmodule

>>> hw/rtl/char_lcd_nibble_write_sequencer.sv
// Order: an accepted request loads the datapath registers, then its first pin state
// enters the single output register once it is free. Throughput: one pin state per
// cycle while out_ready is high, as the controller refills that register; a byte
// request gives 4 pin states and init 21; no new request is taken until the last is emitted.
// Reset: synchronous, active low; output empties, timing registers load 2, 5, 20 ms.
module char_lcd_nibble_write_sequencer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    in_req_type,
  input  logic [7:0]                    in_value,
  input  logic [2:0]                    in_row,
  input  logic [4:0]                    in_column,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_reg_select,
  output logic                          out_enable,
  output logic [3:0]                    out_nibble,
  output logic [7:0]                    out_hold_ms,
  output logic                          out_last,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [clnws_pkg::PADDR_W-1:0] paddr,
  input  logic [clnws_pkg::PDATA_W-1:0] pwdata,
  output logic [clnws_pkg::PDATA_W-1:0] prdata,
  output logic                          pready
);

  clnws_pkg::cmd_t  cmd;
  clnws_pkg::stat_t stat;

  assign pready = 1'b1;

  clnws_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_ready    (in_ready),
    .stat        (stat),
    .cmd         (cmd)
  );

  clnws_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_req_type    (in_req_type),
    .in_value       (in_value),
    .in_row         (in_row),
    .in_column      (in_column),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_reg_select (out_reg_select),
    .out_enable     (out_enable),
    .out_nibble     (out_nibble),
    .out_hold_ms    (out_hold_ms),
    .out_last       (out_last),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata)
  );

endmodule

>>> hw/rtl/clnws_chk.sv
module clnws_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [2:0] in_req_type,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_enable,
  input logic [3:0] out_nibble,
  input logic       out_last
);

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_req_type <= clnws_pkg::REQ_CLEAR) |=> !in_ready)
    else $error("request accepted but sequencer stays ready");

  a_last_is_e_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_enable |-> !out_last)
    else $error("final pin state has E high");

  a_e_low_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_enable |=>
      out_valid && !out_enable && (out_nibble == $past(out_nibble)))
    else $error("E high not followed by E low with same nibble");

  a_idle_holds_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && out_valid |-> out_last)
    else $error("sequencer idle with a non-final pin state pending");

endmodule

bind char_lcd_nibble_write_sequencer clnws_chk u_clnws_chk (.*);

>>> tb/tb_char_lcd_nibble_write_sequencer.sv
module tb_char_lcd_nibble_write_sequencer;

  localparam logic [2:0] REQ_SPARE_LO = 3'd5;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;
  localparam logic [1:0] REG_SPARE    = 2'd3;
  localparam logic [31:0] INIT_BYTES  = 32'h02_28_0C_06;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 10;

  typedef struct packed {
    logic       rs;
    logic       en;
    logic [3:0] nib;
    logic [7:0] hold;
    logic       last;
  } pin_state_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_req_type = '0;
  logic [7:0] in_value = '0;
  logic [2:0] in_row = '0;
  logic [4:0] in_column = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_reg_select;
  logic out_enable;
  logic [3:0] out_nibble;
  logic [7:0] out_hold_ms;
  logic out_last;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [clnws_pkg::PADDR_W-1:0] paddr = '0;
  logic [clnws_pkg::PDATA_W-1:0] pwdata = '0;
  logic [clnws_pkg::PDATA_W-1:0] prdata;
  logic pready;

  pin_state_t expected_pins[$];
  pin_state_t want_pin;
  logic [7:0] pulse_ms = clnws_pkg::RST_ENABLE_PULSE;
  logic [7:0] clr_ms   = clnws_pkg::RST_CLEAR_WAIT;
  logic [7:0] pwr_ms   = clnws_pkg::RST_POWER_UP;
  bit jitter_on = 1'b1;
  int mismatch_cnt = 0;
  int stall_left = 0;
  int quiet_cycles = 0;

  char_lcd_nibble_write_sequencer dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_req_type(in_req_type), .in_value(in_value), .in_row(in_row),
    .in_column(in_column),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_reg_select(out_reg_select), .out_enable(out_enable),
    .out_nibble(out_nibble), .out_hold_ms(out_hold_ms), .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  function automatic void add_pin(logic rs, logic en, logic [3:0] nib, logic [7:0] hold);
    pin_state_t p;
    p.rs = rs;
    p.en = en;
    p.nib = nib;
    p.hold = hold;
    p.last = 1'b0;
    expected_pins.push_back(p);
  endfunction

  function automatic void add_byte(logic rs, logic [7:0] b);
    add_pin(rs, 1'b1, b[7:4], pulse_ms);
    add_pin(rs, 1'b0, b[7:4], 8'd0);
    add_pin(rs, 1'b1, b[3:0], pulse_ms);
    add_pin(rs, 1'b0, b[3:0], 8'd0);
  endfunction

  function automatic void add_clear();
    pin_state_t tail;
    add_byte(1'b0, clnws_pkg::CLEAR_BYTE);
    tail = expected_pins.pop_back();
    tail.hold = clr_ms;
    expected_pins.push_back(tail);
  endfunction

  function automatic void predict_pins(logic [2:0] req, logic [7:0] val,
                                       logic [2:0] row, logic [4:0] col);
    int n0;
    logic [7:0] addr;
    pin_state_t tail;
    n0 = expected_pins.size();
    case (req)
      clnws_pkg::REQ_INIT: begin
        add_pin(1'b0, 1'b0, 4'h0, pwr_ms);
        for (int i = 0; i < 4; i++) add_byte(1'b0, INIT_BYTES[31-8*i -: 8]);
        add_clear();
      end
      clnws_pkg::REQ_CMD:  add_byte(1'b0, val);
      clnws_pkg::REQ_DATA: add_byte(1'b1, val);
      clnws_pkg::REQ_CURSOR: begin
        case (row)
          3'd0:    addr = clnws_pkg::ROW0_BASE + {3'd0, col};
          3'd1:    addr = clnws_pkg::ROW1_BASE + {3'd0, col};
          3'd2:    addr = clnws_pkg::ROW2_BASE + {3'd0, col};
          3'd3:    addr = clnws_pkg::ROW3_BASE + {3'd0, col};
          default: addr = clnws_pkg::HOME_ADDR;
        endcase
        add_byte(1'b0, addr);
      end
      clnws_pkg::REQ_CLEAR: add_clear();
      default: ;
    endcase
    if (expected_pins.size() > n0) begin
      tail = expected_pins.pop_back();
      tail.last = 1'b1;
      expected_pins.push_back(tail);
    end
  endfunction

  // caller sits on a rising edge; valid stays up between back-to-back items
  task automatic send_req(input logic [2:0] req, input logic [7:0] val,
                          input logic [2:0] row, input logic [4:0] col);
    if (jitter_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_value <= val;
    in_row <= row;
    in_column <= col;
    do @(posedge clk); while (!in_ready);
    predict_pins(req, val, row, col);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
    in_valid <= 1'b0;
    while (expected_pins.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      clnws_pkg::REG_ENABLE_PULSE: pulse_ms = val;
      clnws_pkg::REG_CLEAR_WAIT:   clr_ms = val;
      clnws_pkg::REG_POWER_UP:     pwr_ms = val;
      default: ;
    endcase
  endtask

  function automatic logic [7:0] pick_ms();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [2:0] pick_req();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return clnws_pkg::REQ_INIT;
    if (r == 1) return 3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
    if (r < 6) return clnws_pkg::REQ_CMD;
    if (r < 10) return clnws_pkg::REQ_DATA;
    if (r < 16) return clnws_pkg::REQ_CURSOR;
    return clnws_pkg::REQ_CLEAR;
  endfunction

  task automatic test_power_up_init();
    send_req(clnws_pkg::REQ_INIT, 8'($urandom), 3'($urandom), 5'($urandom));
    send_req(clnws_pkg::REQ_CLEAR, 8'($urandom), 3'($urandom), 5'($urandom));
  endtask

  task automatic test_byte_requests();
    send_req(clnws_pkg::REQ_CMD, 8'h00, 3'd0, 5'd0);
    send_req(clnws_pkg::REQ_CMD, 8'hFF, 3'd7, 5'd31);
    send_req(clnws_pkg::REQ_CMD, 8'h5A, 3'($urandom), 5'($urandom));
    send_req(clnws_pkg::REQ_DATA, 8'h00, 3'd7, 5'd31);
    send_req(clnws_pkg::REQ_DATA, 8'hFF, 3'd0, 5'd0);
    send_req(clnws_pkg::REQ_DATA, 8'hA5, 3'($urandom), 5'($urandom));
  endtask

  task automatic test_cursor_rows();
    send_req(clnws_pkg::REQ_CURSOR, 8'($urandom), 3'd0, 5'd0);
    for (int r = 0; r < 4; r++)
      send_req(clnws_pkg::REQ_CURSOR, 8'($urandom), 3'(r), 5'd19);
    send_req(clnws_pkg::REQ_CURSOR, 8'($urandom), 3'd3, 5'd31);
    for (int r = 4; r < 8; r++)
      send_req(clnws_pkg::REQ_CURSOR, 8'($urandom), 3'(r), 5'($urandom));
  endtask

  task automatic test_unused_requests();
    for (int r = REQ_SPARE_LO; r <= REQ_SPARE_HI; r++)
      send_req(3'(r), 8'($urandom), 3'($urandom), 5'($urandom));
    send_req(clnws_pkg::REQ_DATA, 8'($urandom), 3'($urandom), 5'($urandom));
  endtask

  task automatic test_register_extremes();
    cfg_write(clnws_pkg::REG_ENABLE_PULSE, 8'd0);
    cfg_write(clnws_pkg::REG_CLEAR_WAIT, 8'd0);
    cfg_write(clnws_pkg::REG_POWER_UP, 8'd0);
    send_req(clnws_pkg::REQ_INIT, 8'($urandom), 3'($urandom), 5'($urandom));
    cfg_write(clnws_pkg::REG_ENABLE_PULSE, 8'd255);
    cfg_write(clnws_pkg::REG_CLEAR_WAIT, 8'd255);
    cfg_write(clnws_pkg::REG_POWER_UP, 8'd255);
    send_req(clnws_pkg::REQ_INIT, 8'($urandom), 3'($urandom), 5'($urandom));
    send_req(clnws_pkg::REQ_CLEAR, 8'($urandom), 3'($urandom), 5'($urandom));
    // write to an unmapped register must leave everything as is
    cfg_write(REG_SPARE, 8'd0);
    send_req(clnws_pkg::REQ_CLEAR, 8'($urandom), 3'($urandom), 5'($urandom));
  endtask

  task automatic test_random_traffic();
    int sent;
    logic [2:0] req;
    for (int phase = 0; phase < 8; phase++) begin
      cfg_write(clnws_pkg::REG_ENABLE_PULSE, pick_ms());
      cfg_write(clnws_pkg::REG_CLEAR_WAIT, pick_ms());
      cfg_write(clnws_pkg::REG_POWER_UP, pick_ms());
      if ($urandom_range(0, 3) == 0) cfg_write(REG_SPARE, 8'($urandom));
      jitter_on = (phase != 3) && (phase != 7);
      sent = 0;
      while (sent < 52) begin
        req = pick_req();
        send_req(req, 8'($urandom), 3'($urandom), 5'($urandom));
        if (req <= clnws_pkg::REQ_CLEAR) sent++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (jitter_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 8);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_pins.size() == 0) begin
        $error("pin state with no pending request: rs %0d e %0d nibble %0h hold %0d",
               out_reg_select, out_enable, out_nibble, out_hold_ms);
        mismatch_cnt++;
      end else begin
        want_pin = expected_pins.pop_front();
        if (out_reg_select !== want_pin.rs) begin
          $error("reg_select: expected %0d, actual %0d", want_pin.rs, out_reg_select);
          mismatch_cnt++;
        end
        if (out_enable !== want_pin.en) begin
          $error("enable: expected %0d, actual %0d", want_pin.en, out_enable);
          mismatch_cnt++;
        end
        if (out_nibble !== want_pin.nib) begin
          $error("nibble: expected %0h, actual %0h", want_pin.nib, out_nibble);
          mismatch_cnt++;
        end
        if (out_hold_ms !== want_pin.hold) begin
          $error("hold_ms: expected %0d, actual %0d", want_pin.hold, out_hold_ms);
          mismatch_cnt++;
        end
        if (out_last !== want_pin.last) begin
          $error("last: expected %0d, actual %0d", want_pin.last, out_last);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_power_up_init();
    test_byte_requests();
    test_cursor_rows();
    test_unused_requests();
    test_register_extremes();
    test_random_traffic();
    in_valid <= 1'b0;
    while (expected_pins.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && expected_pins.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
